/* src/mdsa_pkg.sv */
// Shared constants, types and command/status structs for the seat allocator.
package mdsa_pkg;

  localparam int MAX_SLOTS     = 256;
  localparam int SLOTS_PER_ROW = 4;
  localparam int NUM_ROWS      = MAX_SLOTS / SLOTS_PER_ROW;
  localparam int ROW_AW        = $clog2(NUM_ROWS);
  localparam int ROW_SEL_W     = $clog2(SLOTS_PER_ROW);
  localparam int SLOT_W        = 8;
  localparam int NSEAT_W       = 9;

  localparam logic [NSEAT_W-1:0] NSEAT_RESET = NSEAT_W'(MAX_SLOTS);
  localparam logic               ACT_ALLOC   = 1'b0;
  localparam logic               ACT_RELEASE = 1'b1;

  typedef logic [SLOT_W-1:0]        slot_t;
  typedef logic [NSEAT_W-1:0]       nseat_t;
  typedef logic [ROW_AW-1:0]        row_addr_t;
  typedef logic [SLOTS_PER_ROW-1:0] row_bits_t;

  typedef struct packed {
    logic      capture;
    logic      scan_clr;
    logic      scan_rd;
    row_addr_t scan_row;
    logic      fin;
    logic      alloc_rd;
    logic      alloc_wr;
    logic      rel_rd;
    logic      rel_wr;
    logic      out_load;
  } mdsa_cmd_t;

  typedef struct packed {
    logic res_full;
    logic out_busy;
  } mdsa_sts_t;

endpackage

/* src/mdsa_if.sv */
// Request, response and configuration channel interfaces.
interface mdsa_req_if import mdsa_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  action;
  slot_t slot_index;

  modport source (output valid, output action, output slot_index, input ready);
  modport sink   (input valid, input action, input slot_index, output ready);
endinterface

interface mdsa_rsp_if import mdsa_pkg::*; ();
  logic  valid;
  logic  ready;
  slot_t chosen_slot;
  logic  row_full;

  modport source (output valid, output chosen_slot, output row_full, input ready);
  modport sink   (input valid, input chosen_slot, input row_full, output ready);
endinterface

interface mdsa_cfg_if import mdsa_pkg::*; ();
  logic   valid;
  logic   ready;
  nseat_t num_seats;

  modport source (output valid, output num_seats, input ready);
  modport sink   (input valid, input num_seats, output ready);
endinterface

/* src/mdsa_ram.sv */
// Generic simple dual-port RAM with registered read data.
module mdsa_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/mdsa_dp.sv */
// Datapath: occupancy memory, gap scan, result and configuration registers.
module mdsa_dp import mdsa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  mdsa_cmd_t cmd,
  output mdsa_sts_t sts,
  input  slot_t     in_slot_index,
  input  logic      cfg_valid,
  input  nseat_t    cfg_num_seats,
  input  logic      out_ready,
  output logic      out_valid,
  output slot_t     out_chosen_slot,
  output logic      out_row_full
);

  nseat_t                  num_seats_r;
  slot_t                   idx_r;
  logic [NUM_ROWS-1:0]     row_valid_r;
  row_addr_t               rd_row_r;
  logic                    proc_r;
  logic                    any_r, any_nxt;
  logic                    found_r, found_nxt;
  slot_t                   prev_r, prev_nxt;
  slot_t                   best_dist_r, best_dist_nxt;
  slot_t                   best_slot_r, best_slot_nxt;
  slot_t                   res_slot_r, res_slot_nxt;
  logic                    res_full_r, res_full_nxt;
  logic                    out_valid_r;
  slot_t                   chosen_r;
  logic                    full_r;

  nseat_t    n_w;
  logic      rel_ok;
  row_addr_t raddr;
  row_bits_t rdata;
  row_bits_t row_eff;
  logic      we;
  row_bits_t wdata;
  slot_t     wr_slot;
  nseat_t    trail_w;
  slot_t     last_slot;

  always_comb begin
    if (num_seats_r == '0) begin
      n_w = NSEAT_W'(1);
    end else if (num_seats_r > NSEAT_W'(MAX_SLOTS)) begin
      n_w = NSEAT_W'(MAX_SLOTS);
    end else begin
      n_w = num_seats_r;
    end
  end

  assign rel_ok  = {1'b0, idx_r} < n_w;
  assign row_eff = row_valid_r[rd_row_r] ? rdata : '0;

  always_comb begin
    if (cmd.scan_rd) begin
      raddr = cmd.scan_row;
    end else if (cmd.alloc_rd) begin
      raddr = res_slot_r[SLOT_W-1:ROW_SEL_W];
    end else if (cmd.rel_rd) begin
      raddr = idx_r[SLOT_W-1:ROW_SEL_W];
    end else begin
      raddr = rd_row_r;
    end
  end

  assign wr_slot = cmd.alloc_wr ? res_slot_r : idx_r;
  assign we      = cmd.alloc_wr || (cmd.rel_wr && rel_ok);

  always_comb begin
    wdata = row_eff;
    wdata[wr_slot[ROW_SEL_W-1:0]] = cmd.alloc_wr;
  end

  mdsa_ram #(
    .WIDTH (SLOTS_PER_ROW),
    .DEPTH (NUM_ROWS)
  ) u_occ_ram (
    .clk   (clk),
    .we    (we),
    .waddr (rd_row_r),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Walk the four slots of the row that just came out of memory.
  always_comb begin
    logic       any_v, found_v;
    slot_t      prev_v, dist_v, slot_v, d_v, cand_v;
    nseat_t     sum_v;
    any_v   = any_r;
    found_v = found_r;
    prev_v  = prev_r;
    dist_v  = best_dist_r;
    slot_v  = best_slot_r;
    for (int k = 0; k < SLOTS_PER_ROW; k++) begin
      cand_v = {rd_row_r, ROW_SEL_W'(k)};
      d_v    = '0;
      sum_v  = '0;
      if (proc_r && row_eff[k] && ({1'b0, cand_v} < n_w)) begin
        if (!any_v) begin
          d_v = cand_v;
          sum_v = '0;
        end else begin
          d_v   = (cand_v - prev_v) >> 1;
          sum_v = {1'b0, cand_v} + {1'b0, prev_v};
        end
        if ((d_v != '0) && (!found_v || (d_v > dist_v))) begin
          found_v = 1'b1;
          dist_v  = d_v;
          slot_v  = sum_v[NSEAT_W-1:1];
        end
        any_v  = 1'b1;
        prev_v = cand_v;
      end
    end
    any_nxt       = any_v;
    found_nxt     = found_v;
    prev_nxt      = prev_v;
    best_dist_nxt = dist_v;
    best_slot_nxt = slot_v;
  end

  assign trail_w   = n_w - NSEAT_W'(1) - {1'b0, prev_r};
  assign last_slot = SLOT_W'(n_w - NSEAT_W'(1));

  always_comb begin
    res_slot_nxt = res_slot_r;
    res_full_nxt = res_full_r;
    if (cmd.fin) begin
      res_slot_nxt = best_slot_r;
      res_full_nxt = !found_r;
      if (!any_r) begin
        res_slot_nxt = '0;
        res_full_nxt = 1'b0;
      end else if ((trail_w[SLOT_W-1:0] != '0) &&
                   (!found_r || (trail_w[SLOT_W-1:0] > best_dist_r))) begin
        res_slot_nxt = last_slot;
        res_full_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_seats_r <= NSEAT_RESET;
      row_valid_r <= '0;
      proc_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        num_seats_r <= cfg_num_seats;
      end
      if (we) begin
        row_valid_r[rd_row_r] <= 1'b1;
      end
      proc_r <= cmd.scan_rd;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_row_r   <= raddr;
    res_slot_r <= res_slot_nxt;
    res_full_r <= res_full_nxt;
    if (cmd.capture) begin
      idx_r <= in_slot_index;
    end
    if (cmd.scan_clr) begin
      any_r       <= 1'b0;
      found_r     <= 1'b0;
      prev_r      <= '0;
      best_dist_r <= '0;
      best_slot_r <= '0;
    end else begin
      any_r       <= any_nxt;
      found_r     <= found_nxt;
      prev_r      <= prev_nxt;
      best_dist_r <= best_dist_nxt;
      best_slot_r <= best_slot_nxt;
    end
    if (cmd.out_load) begin
      chosen_r <= res_full_r ? '0 : res_slot_r;
      full_r   <= res_full_r;
    end
  end

  assign sts.res_full    = res_full_r;
  assign sts.out_busy    = out_valid_r && !out_ready;
  assign out_valid       = out_valid_r;
  assign out_chosen_slot = chosen_r;
  assign out_row_full    = full_r;

endmodule

/* src/mdsa_ctrl.sv */
// Controller state machine that sequences release, scan and allocate.
module mdsa_ctrl import mdsa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_action,
  output logic      in_ready,
  input  mdsa_sts_t sts,
  output mdsa_cmd_t cmd
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_REL_RD   = 9'b000000010,
    S_REL_WR   = 9'b000000100,
    S_SCAN     = 9'b000001000,
    S_DRAIN    = 9'b000010000,
    S_FIN      = 9'b000100000,
    S_ALLOC_RD = 9'b001000000,
    S_ALLOC_WR = 9'b010000000,
    S_RESULT   = 9'b100000000
  } state_t;

  state_t    state_r, state_nxt;
  row_addr_t cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.scan_row = cnt_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (in_action == ACT_RELEASE) begin
            state_nxt = S_REL_RD;
          end else begin
            cmd.scan_clr = 1'b1;
            cnt_nxt      = '0;
            state_nxt    = S_SCAN;
          end
        end
      end
      S_REL_RD: begin
        cmd.rel_rd = 1'b1;
        state_nxt  = S_REL_WR;
      end
      S_REL_WR: begin
        cmd.rel_wr = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        cnt_nxt     = cnt_r + ROW_AW'(1);
        if (cnt_r == ROW_AW'(NUM_ROWS - 1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_ALLOC_RD;
      end
      S_ALLOC_RD: begin
        if (sts.res_full) begin
          state_nxt = S_RESULT;
        end else begin
          cmd.alloc_rd = 1'b1;
          state_nxt    = S_ALLOC_WR;
        end
      end
      S_ALLOC_WR: begin
        cmd.alloc_wr = 1'b1;
        state_nxt    = S_RESULT;
      end
      S_RESULT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

`ifndef SYNTH
  a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && cnt_r == ROW_AW'(NUM_ROWS - 1)) |=> (state_r == S_DRAIN))
    else $error("Scan did not end after the last row.");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !sts.out_busy)
    else $error("Result loaded over a waiting result.");

  a_alloc_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_action == ACT_ALLOC) |=>
      (state_r == S_SCAN && cnt_r == '0))
    else $error("Allocate request did not start a scan at row zero.");

  a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.alloc_wr |-> !sts.res_full)
    else $error("Slot marked while the row was full.");
`endif

endmodule

/* src/max_distance_seat_allocator.sv */
// Top level of the max-distance seat allocator.
// Each release request goes through accept, row read and row write, and gives
// no response. For an allocate request, the occupancy map sits in a 64-row
// memory of four slots per row, and the scan reads one row per cycle for all
// 64 rows, followed by a drain state, a decision state and, unless the row is
// full, a read and write of the chosen row before the response is loaded. A new
// request is taken only once the previous one is finished, while a response may
// still wait at the output. The map reads as all free after reset without a
// clearing pass, and num_seats may be written at any time the block is idle.
module max_distance_seat_allocator import mdsa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  mdsa_req_if.sink          in_req,
  mdsa_rsp_if.source        out_rsp,
  mdsa_cfg_if.sink          cfg_wr
);

  mdsa_cmd_t cmd;
  mdsa_sts_t sts;
  logic      in_ready;

  assign in_req.ready = in_ready;
  assign cfg_wr.ready = 1'b1;

  mdsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_action (in_req.action),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mdsa_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_slot_index   (in_req.slot_index),
    .cfg_valid       (cfg_wr.valid),
    .cfg_num_seats   (cfg_wr.num_seats),
    .out_ready       (out_rsp.ready),
    .out_valid       (out_rsp.valid),
    .out_chosen_slot (out_rsp.chosen_slot),
    .out_row_full    (out_rsp.row_full)
  );

endmodule

/* tb/sv/max_distance_seat_allocator_tb.sv */
// Self-checking testbench for the max-distance seat allocator, with a model of the seat map.
module max_distance_seat_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mdsa_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int PHASE_ITEMS   = 160;
  localparam int NUM_PHASES    = 9;
  localparam int SETTLE_CYCLES = 10;
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_AFTER    = 150;
  localparam int IDLE_PCT      = 29;
  localparam int OPENING_LEN   = 24;

  localparam nseat_t PHASE_SEATS [NUM_PHASES-1] = '{
    9'd256, 9'd7, 9'd1, 9'd64, 9'd3, 9'd255, 9'd0, 9'd130
  };

  typedef enum logic {STEP_REQ, STEP_CFG} step_kind_t;

  typedef struct packed {
    step_kind_t kind;
    logic       action;
    slot_t      slot_index;
    nseat_t     seats;
    logic       typed;
    slot_t      want_slot;
    logic       want_full;
  } step_t;

  typedef struct packed {
    slot_t chosen_slot;
    logic  row_full;
  } seat_result_t;

  logic clk;
  logic rst_n;

  mdsa_req_if req_ch();
  mdsa_rsp_if rsp_ch();
  mdsa_cfg_if cfg_ch();

  max_distance_seat_allocator dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_ch),
    .out_rsp(rsp_ch),
    .cfg_wr (cfg_ch)
  );

  logic [MAX_SLOTS-1:0] seat_taken;
  nseat_t               seat_limit;
  seat_result_t         awaited_results[$];
  int                   error_count  = 0;
  int                   results_seen = 0;
  int                   cycle_count  = 0;
  bit                   calm         = 1'b0;
  step_t                opening_steps [OPENING_LEN];

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int unsigned row_length();
    int unsigned n;
    n = seat_limit;
    if (n < 1) n = 1;
    if (n > MAX_SLOTS) n = MAX_SLOTS;
    return n;
  endfunction

  function automatic void add_awaited(input seat_result_t r);
    awaited_results.insert(awaited_results.size(), r);
  endfunction

  // Applies one request to the seat map and returns 1 when it yields a response.
  function automatic bit apply_seat_request(input logic action, input slot_t idx,
                                            output seat_result_t res);
    int unsigned n, prev, best_dist, best_slot, gap, cand;
    bit any, found;
    n = row_length();
    res = '{chosen_slot: '0, row_full: 1'b0};
    if (action == ACT_RELEASE) begin
      if (idx < n) seat_taken[idx] = 1'b0;
      return 1'b0;
    end
    any = 1'b0;
    found = 1'b0;
    prev = 0;
    best_dist = 0;
    best_slot = 0;
    for (int unsigned i = 0; i < n; i++) begin
      if (!seat_taken[i]) continue;
      if (!any) begin
        gap = i;
        cand = 0;
      end else begin
        gap = (i - prev) / 2;
        cand = (i + prev) / 2;
      end
      if (gap > 0 && (!found || gap > best_dist)) begin
        found = 1'b1;
        best_dist = gap;
        best_slot = cand;
      end
      any = 1'b1;
      prev = i;
    end
    if (!any) begin
      found = 1'b1;
      best_slot = 0;
    end else begin
      gap = n - 1 - prev;
      if (gap > 0 && (!found || gap > best_dist)) begin
        found = 1'b1;
        best_slot = n - 1;
      end
    end
    if (!found) begin
      res.row_full = 1'b1;
    end else begin
      seat_taken[best_slot] = 1'b1;
      res.chosen_slot = slot_t'(best_slot);
    end
    return 1'b1;
  endfunction

  function automatic step_t alloc_step(input logic typed = 1'b0, input slot_t want_slot = '0,
                                       input logic want_full = 1'b0);
    return '{kind: STEP_REQ, action: ACT_ALLOC, slot_index: '1, seats: '0,
             typed: typed, want_slot: want_slot, want_full: want_full};
  endfunction

  function automatic step_t release_step(input slot_t idx);
    return '{kind: STEP_REQ, action: ACT_RELEASE, slot_index: idx, seats: '0,
             typed: 1'b0, want_slot: '0, want_full: 1'b0};
  endfunction

  function automatic step_t cfg_step(input nseat_t seats);
    return '{kind: STEP_CFG, action: ACT_ALLOC, slot_index: '0, seats: seats,
             typed: 1'b0, want_slot: '0, want_full: 1'b0};
  endfunction

  task automatic send_request(input logic action, input slot_t idx,
                              output bit has_result, output seat_result_t res);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.action     <= action;
    req_ch.slot_index <= idx;
    do @(posedge clk); while (!req_ch.ready);
    has_result = apply_seat_request(action, idx, res);
  endtask

  // A release request gives no response, so a settle wait after all awaited responses are seen lets it finish.
  task automatic wait_drained();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_seat_count(input nseat_t value);
    wait_drained();
    cfg_ch.valid     <= 1'b1;
    cfg_ch.num_seats <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    seat_limit = value;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    step_t        st;
    bit           has_result;
    seat_result_t res;
    int unsigned  n;
    int unsigned  roll;
    logic         action;
    slot_t        idx;

    seat_taken        = '0;
    seat_limit        = NSEAT_RESET;
    rst_n             = 1'b0;
    req_ch.valid      = 1'b0;
    req_ch.action     = ACT_ALLOC;
    req_ch.slot_index = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.num_seats  = NSEAT_RESET;

    opening_steps = '{
      alloc_step(1'b1, 8'd0, 1'b0),
      alloc_step(1'b1, 8'd255, 1'b0),
      alloc_step(1'b1, 8'd127, 1'b0),
      alloc_step(),
      release_step(8'd255),
      release_step(8'd200),
      release_step(8'd0),
      alloc_step(),
      alloc_step(),
      cfg_step(9'd2),
      alloc_step(),
      alloc_step(),
      alloc_step(),
      cfg_step(9'd1),
      release_step(8'd0),
      alloc_step(1'b1, 8'd0, 1'b0),
      alloc_step(1'b1, 8'd0, 1'b1),
      release_step(8'd255),
      cfg_step(9'd0),
      alloc_step(1'b1, 8'd0, 1'b1),
      cfg_step(9'd511),
      alloc_step(),
      release_step(8'd128),
      cfg_step(NSEAT_RESET)
    };

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (opening_steps[k]) begin
      st = opening_steps[k];
      if (st.kind == STEP_CFG) begin
        write_seat_count(st.seats);
      end else begin
        send_request(st.action, st.slot_index, has_result, res);
        if (has_result && st.typed) begin
          add_awaited('{chosen_slot: st.want_slot, row_full: st.want_full});
        end else if (has_result) begin
          add_awaited(res);
        end
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < NUM_PHASES - 1) begin
        write_seat_count(PHASE_SEATS[p]);
      end else begin
        write_seat_count(nseat_t'($urandom_range(1, MAX_SLOTS)));
      end
      calm = (p == 3);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        n = row_length();
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
          action = ACT_ALLOC;
          idx = slot_t'($urandom);
        end else if (roll < 92) begin
          action = ACT_RELEASE;
          idx = slot_t'($urandom_range(0, n - 1));
          for (int t = 0; t < 8 && !seat_taken[idx]; t++) begin
            idx = slot_t'($urandom_range(0, n - 1));
          end
        end else begin
          action = ACT_RELEASE;
          idx = slot_t'($urandom);
        end
        send_request(action, idx, has_result, res);
        if (has_result) add_awaited(res);
        if (p == 5 && k == PHASE_ITEMS / 2) wait_drained();
      end
    end
    calm = 1'b0;

    wait_drained();
    if (error_count == 0) begin
      $display("max_distance_seat_allocator_tb: PASS");
    end else begin
      $display("max_distance_seat_allocator_tb: FAIL");
    end
    $finish;
  end

  // The response side stalls once for a long stretch so that a request backs up at the input.
  initial begin
    bit held;
    held = 1'b0;
    rsp_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held && results_seen >= HOLD_AFTER) begin
        held = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      rsp_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin : check_response
    seat_result_t want;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected response: chosen_slot %0d row_full %0b",
               rsp_ch.chosen_slot, rsp_ch.row_full);
        error_count++;
      end else begin
        want = awaited_results.pop_front();
        results_seen++;
        if (rsp_ch.chosen_slot !== want.chosen_slot) begin
          $error("chosen_slot: expected %0d, actual %0d", want.chosen_slot, rsp_ch.chosen_slot);
          error_count++;
        end
        if (rsp_ch.row_full !== want.row_full) begin
          $error("row_full: expected %0b, actual %0b", want.row_full, rsp_ch.row_full);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("max_distance_seat_allocator_tb: FAIL");
      $finish;
    end
  end

endmodule

/* sim.f */
src/mdsa_pkg.sv
src/mdsa_if.sv
src/mdsa_ram.sv
src/mdsa_dp.sv
src/mdsa_ctrl.sv
src/max_distance_seat_allocator.sv
tb/sv/max_distance_seat_allocator_tb.sv
